@@ src/pfmd_pkg.sv @@
// Package for the peak finder with minimum distance.
// Holds widths, register indexes, the front-to-back queue entry type.
// No dependencies.
package pfmd_pkg;
   localparam int MaxSamples    = 1024;
   localparam int MaxCandidates = 64;
   localparam int PosW  = 10;
   localparam int ValW  = 16;
   localparam int CntW  = 7;
   localparam int IdxW  = 6;
   localparam int SIdxW = 11;

   localparam logic [1:0] RegMinDistance   = 2'd0;
   localparam logic [1:0] RegLowBound      = 2'd1;
   localparam logic [1:0] RegHighBound     = 2'd2;
   localparam logic [1:0] RegPriorityFloor = 2'd3;

   // One queue entry: a candidate, the end-of-frame marker, or both.
   typedef struct packed {
      logic                   is_end;
      logic                   is_cand;
      logic [PosW-1:0]        position;
      logic signed [ValW-1:0] value;
      logic                   dropped;
   } cand_type;

   typedef struct packed {
      logic [PosW-1:0]        peak_position;
      logic signed [ValW-1:0] peak_value;
      logic                   none_found;
      logic                   candidates_dropped;
      logic                   last_result;
   } rsp_type;
endpackage

@@ src/pfmd_if.sv @@
// Handshake channel interfaces for the peak finder.
// No dependencies.
interface pfmd_req_if (input logic clock);
   logic                   valid;
   logic                   ready;
   logic signed [15:0]     sample;
   logic                   frame_end;
   modport source (output valid, sample, frame_end, input ready);
   modport sink   (input valid, sample, frame_end, output ready);
endinterface

interface pfmd_rsp_if (input logic clock);
   logic                   valid;
   logic                   ready;
   logic [9:0]             peak_position;
   logic signed [15:0]     peak_value;
   logic                   none_found;
   logic                   candidates_dropped;
   logic                   last_result;
   modport source (output valid, peak_position, peak_value, none_found,
                   candidates_dropped, last_result, input ready);
   modport sink   (input valid, peak_position, peak_value, none_found,
                   candidates_dropped, last_result, output ready);
endinterface

interface pfmd_csr_if (input logic clock);
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ src/pfmd_front.sv @@
// Front end: slope tracking and candidate detection per sample.
// Depends on pfmd_pkg.
module pfmd_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [15:0]            sample,
   input  logic                          frame_end,
   output logic                          q_push,
   output pfmd_pkg::cand_type            q_data,
   input  logic                          q_full
);
   logic signed [15:0]              prev_ff, prev_in;
   logic signed [1:0]               slope_ff, slope_in, slope;
   logic [pfmd_pkg::SIdxW-1:0]      idx_ff, idx_in;
   logic [pfmd_pkg::CntW-1:0]       cnt_ff, cnt_in;
   logic                            ovf_ff, ovf_in;
   logic                            take, live, cand, store;

   // Queue needs room for one entry: an item pushes at most one, a candidate, the end marker or both.
   assign in_ready = !q_full;
   assign take = in_valid && in_ready;
   assign live = idx_ff < pfmd_pkg::SIdxW'(pfmd_pkg::MaxSamples);
   assign slope = (sample > prev_ff) ? 2'sd1 : ((sample < prev_ff) ? -2'sd1 : 2'sd0);
   assign cand = live && idx_ff >= pfmd_pkg::SIdxW'(2) && slope < slope_ff;
   assign store = cand && cnt_ff < pfmd_pkg::CntW'(pfmd_pkg::MaxCandidates);

   // Candidate and end both on one item: end carries candidate data too.
   always_comb begin
      q_push = take && (store || frame_end);
      q_data.is_end   = frame_end;
      q_data.is_cand  = store;
      q_data.position = pfmd_pkg::PosW'(idx_ff - 1'b1);
      q_data.value    = prev_ff;
      q_data.dropped  = ovf_ff || (cand && !store);
      prev_in = prev_ff; slope_in = slope_ff; idx_in = idx_ff;
      cnt_in = cnt_ff; ovf_in = ovf_ff;
      if (take) begin
         if (live) begin
            if (idx_ff >= pfmd_pkg::SIdxW'(1)) slope_in = slope;
            prev_in = sample;
            idx_in = idx_ff + 1'b1;
            if (store) cnt_in = cnt_ff + 1'b1;
            if (cand && !store) ovf_in = 1'b1;
         end
         if (frame_end) begin
            prev_in = '0; slope_in = '0; idx_in = '0; cnt_in = '0; ovf_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0; slope_ff <= '0; idx_ff <= '0; cnt_ff <= '0; ovf_ff <= 1'b0;
      end else begin
         prev_ff <= prev_in; slope_ff <= slope_in; idx_ff <= idx_in;
         cnt_ff <= cnt_in; ovf_ff <= ovf_in;
      end
   end
endmodule

@@ src/pfmd_queue.sv @@
// Short FIFO between front and back end.
// Depends on pfmd_pkg.
module pfmd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  pfmd_pkg::cand_type push_data,
   output logic               full,
   input  logic               pop,
   output pfmd_pkg::cand_type pop_data,
   output logic               not_empty
);
   pfmd_pkg::cand_type mem_ff [4];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;

   assign full = cnt_ff == 3'd4;
   assign not_empty = cnt_ff != 3'd0;
   assign pop_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + 3'(push) - 3'(pop);
      end
   end
endmodule

@@ src/pfmd_back.sv @@
// Back end: candidate table, suppression pass and result emission.
// Depends on pfmd_pkg.
module pfmd_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   input  pfmd_pkg::cand_type      q_data,
   output logic                    q_pop,
   input  logic [9:0]              min_distance,
   input  logic signed [15:0]      low_bound,
   input  logic signed [15:0]      high_bound,
   input  logic signed [15:0]      priority_floor,
   output logic                    out_valid,
   input  logic                    out_ready,
   output pfmd_pkg::rsp_type       out_data
);
   typedef enum logic [2:0] {
      S_LOAD, S_SCAN, S_SUPP, S_OUT, S_EMIT, S_NONE
   } state_type;

   localparam int N  = pfmd_pkg::MaxCandidates;
   localparam int EW = pfmd_pkg::PosW + pfmd_pkg::ValW;

   state_type                        state_ff, state_in;
   logic [EW-1:0]                    tbl_ff [N];
   logic [EW-1:0]                    rd_ff, wr_data;
   logic                             wr_en;
   logic [pfmd_pkg::IdxW-1:0]        wr_addr, rd_addr;
   logic [N-1:0]                     vis_ff, vis_in, sup_ff, sup_in;
   logic [pfmd_pkg::CntW-1:0]        n_ff, n_in;
   logic [pfmd_pkg::IdxW-1:0]        j_ff, j_in, best_ff, best_in;
   logic signed [pfmd_pkg::ValW-1:0] bval_ff, bval_in;
   logic [pfmd_pkg::PosW-1:0]        bpos_ff, bpos_in;
   logic                             found_ff, found_in, drop_ff, drop_in;
   pfmd_pkg::rsp_type                pend_ff, pend_in, out_ff, out_in;
   logic                             pend_vld_ff, pend_vld_in, ov_ff, ov_in;
   logic                             load_out, slot_free, last_j, keep;
   logic [pfmd_pkg::PosW-1:0]        cur_pos, gap;
   logic signed [pfmd_pkg::ValW-1:0] cur_val;

   assign q_pop = (state_ff == S_LOAD) && q_valid;
   assign out_valid = ov_ff;
   assign out_data = out_ff;
   // Table entry j_ff, read ahead at the next index into a register.
   assign cur_pos = rd_ff[EW-1:pfmd_pkg::ValW];
   assign cur_val = $signed(rd_ff[pfmd_pkg::ValW-1:0]);
   assign rd_addr = j_in;
   assign slot_free = !ov_ff || out_ready;
   assign last_j = {1'b0, j_ff} == n_ff - 1'b1;
   assign gap = (cur_pos > bpos_ff) ? cur_pos - bpos_ff : bpos_ff - cur_pos;
   assign keep = !sup_ff[j_ff] && cur_val >= low_bound && cur_val <= high_bound;

   always_comb begin
      state_in = state_ff; n_in = n_ff; j_in = j_ff; best_in = best_ff;
      bval_in = bval_ff; bpos_in = bpos_ff; found_in = found_ff; drop_in = drop_ff;
      vis_in = vis_ff; sup_in = sup_ff; pend_in = pend_ff; pend_vld_in = pend_vld_ff;
      out_in = out_ff; load_out = 1'b0;
      wr_en = 1'b0;
      wr_addr = n_ff[pfmd_pkg::IdxW-1:0];
      wr_data = {q_data.position, q_data.value};
      unique case (state_ff)
         S_LOAD: if (q_valid) begin
            drop_in = q_data.dropped;
            if (q_data.is_cand) begin
               wr_en = 1'b1;
               n_in = n_ff + 1'b1;
            end
            if (q_data.is_end) begin
               j_in = '0; found_in = 1'b0; bval_in = priority_floor;
               state_in = (n_ff == '0 && !q_data.is_cand) ? S_NONE : S_SCAN;
            end
         end
         S_SCAN: begin
            // Find highest unvisited candidate above the floor.
            if (!vis_ff[j_ff] && cur_val > bval_ff) begin
               best_in = j_ff; bval_in = cur_val; bpos_in = cur_pos; found_in = 1'b1;
            end
            if (last_j) begin
               j_in = '0; state_in = S_SUPP;
            end else j_in = j_ff + 1'b1;
         end
         S_SUPP: begin
            found_in = 1'b0;
            if (!found_ff) state_in = S_EMIT;
            else begin
               vis_in[best_ff] = 1'b1;
               if (sup_ff[best_ff]) begin
                  bval_in = priority_floor; state_in = S_SCAN;
               end else state_in = S_OUT;
            end
         end
         S_OUT: begin
            // Suppression sweep around the chosen peak.
            if (j_ff != best_ff && gap <= min_distance) sup_in[j_ff] = 1'b1;
            if (last_j) begin
               j_in = '0; bval_in = priority_floor; state_in = S_SCAN;
            end else j_in = j_ff + 1'b1;
         end
         S_EMIT: if (!(keep && pend_vld_ff && !slot_free)) begin
            // Hold one kept peak back so the final one can carry last_result.
            if (keep) begin
               if (pend_vld_ff) begin
                  load_out = 1'b1; out_in = pend_ff;
               end
               pend_in.peak_position = cur_pos;
               pend_in.peak_value = cur_val;
               pend_in.none_found = 1'b0;
               pend_in.candidates_dropped = drop_ff;
               pend_in.last_result = 1'b0;
               pend_vld_in = 1'b1;
            end
            if (last_j) begin
               j_in = '0; state_in = S_NONE;
            end else j_in = j_ff + 1'b1;
         end
         S_NONE: if (slot_free) begin
            load_out = 1'b1;
            if (pend_vld_ff) begin
               out_in = pend_ff; out_in.last_result = 1'b1;
            end else begin
               out_in = '0;
               out_in.none_found = 1'b1;
               out_in.candidates_dropped = drop_ff;
               out_in.last_result = 1'b1;
            end
            pend_vld_in = 1'b0; n_in = '0; vis_in = '0; sup_in = '0; state_in = S_LOAD;
         end
         default: state_in = S_LOAD;
      endcase
      ov_in = load_out ? 1'b1 : (out_ready ? 1'b0 : ov_ff);
   end

   always_ff @(posedge clock) begin
      if (wr_en) tbl_ff[wr_addr] <= wr_data;
      rd_ff <= (wr_en && wr_addr == rd_addr) ? wr_data : tbl_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD; n_ff <= '0; j_ff <= '0; best_ff <= '0; bval_ff <= '0;
         bpos_ff <= '0; found_ff <= 1'b0; drop_ff <= 1'b0; vis_ff <= '0; sup_ff <= '0;
         pend_ff <= '0; pend_vld_ff <= 1'b0; out_ff <= '0; ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in; n_ff <= n_in; j_ff <= j_in; best_ff <= best_in;
         bval_ff <= bval_in; bpos_ff <= bpos_in; found_ff <= found_in; drop_ff <= drop_in;
         vis_ff <= vis_in; sup_ff <= sup_in; pend_ff <= pend_in;
         pend_vld_ff <= pend_vld_in; out_ff <= out_in; ov_ff <= ov_in;
      end
   end
endmodule

@@ src/peak_finder_min_distance.sv @@
// Top level of the peak finder with minimum distance.
// Depends on pfmd_pkg, pfmd_if, pfmd_front, pfmd_queue, pfmd_back.
//
// channel | dir | fields
// req     | in  | sample, frame_end
// rsp     | out | peak_position, peak_value, none_found, candidates_dropped, last_result
// csr     | in  | index 0..3, data
//
// Samples enter one per cycle while the queue has room. At frame end the back
// end scans the n-entry table, makes one decision for each visited
// candidate, and sweeps the table again to suppress the neighbors of each
// candidate that still stands; one last scan finds none. Emission then
// steps through every stored candidate and ends with one final item.
// Reset is synchronous; registers return to their reset values.
// A stalled rsp holds the back end; the front stalls when the queue fills.
module peak_finder_min_distance (
   input logic         clock,
   input logic         reset,
   pfmd_req_if.sink    req,
   pfmd_rsp_if.source  rsp,
   pfmd_csr_if.sink    csr
);
   logic [9:0]         min_distance_ff;
   logic signed [15:0] low_bound_ff, high_bound_ff, priority_floor_ff;
   logic               push, full, pop, ne, bvalid;
   pfmd_pkg::cand_type pdata, qdata;
   pfmd_pkg::rsp_type  bdata;

   assign csr.ready = 1'b1;

   // Register file: accept writes at any time.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_distance_ff <= '0;
         low_bound_ff <= -16'sd32768;
         high_bound_ff <= 16'sd32767;
         priority_floor_ff <= -16'sd4096;
      end else if (csr.valid) begin
         unique case (csr.index)
            pfmd_pkg::RegMinDistance:   min_distance_ff <= csr.data[9:0];
            pfmd_pkg::RegLowBound:      low_bound_ff <= csr.data;
            pfmd_pkg::RegHighBound:     high_bound_ff <= csr.data;
            pfmd_pkg::RegPriorityFloor: priority_floor_ff <= csr.data;
            default: ;
         endcase
      end
   end

   pfmd_front u_front (
      .clock, .reset, .in_valid(req.valid), .in_ready(req.ready),
      .sample(req.sample), .frame_end(req.frame_end),
      .q_push(push), .q_data(pdata), .q_full(full)
   );

   // A candidate that rides with frame end stays in one entry with both flags set.
   pfmd_queue u_queue (
      .clock, .reset, .push(push), .push_data(pdata), .full(full),
      .pop, .pop_data(qdata), .not_empty(ne)
   );

   pfmd_back u_back (
      .clock, .reset, .q_valid(ne), .q_data(qdata), .q_pop(pop),
      .min_distance(min_distance_ff), .low_bound(low_bound_ff),
      .high_bound(high_bound_ff), .priority_floor(priority_floor_ff),
      .out_valid(bvalid), .out_ready(rsp.ready), .out_data(bdata)
   );

   assign rsp.valid = bvalid;
   assign rsp.peak_position = bdata.peak_position;
   assign rsp.peak_value = bdata.peak_value;
   assign rsp.none_found = bdata.none_found;
   assign rsp.candidates_dropped = bdata.candidates_dropped;
   assign rsp.last_result = bdata.last_result;
endmodule

@@ src/pfmd_checker.sv @@
// Port-level checker for the peak finder, bound to the top level.
// Depends on nothing but the top level's port names.
module pfmd_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_none_found,
   input logic rsp_last_result,
   input logic [9:0] rsp_peak_position
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp dropped");
   a_none_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_none_found |-> rsp_last_result) else $error("none not last");
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_none_found |-> rsp_peak_position == 10'd0)
      else $error("none with position");
endmodule

bind peak_finder_min_distance pfmd_checker u_chk (
   .clock, .reset, .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_none_found(rsp.none_found), .rsp_last_result(rsp.last_result),
   .rsp_peak_position(rsp.peak_position)
);
